// ===== hdl/clbf_pkg.sv =====
// shared constants and types for the cache-line blocked bloom filter
// no dependencies; imported by the top level
package clbf_pkg;

    localparam int HASH_W           = 32;
    localparam int ROT_DELTA        = 17;
    localparam int PROBE_COUNT_W    = 5;
    localparam int LINE_COUNT_W     = 11;
    localparam int MAX_LINES_DEF    = 1024;
    localparam int LINE_BITS_DEF    = 512;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_ADDR_W       = 3;
    localparam int M_TDATA_W        = 8;

    localparam logic [PROBE_COUNT_W-1:0] PROBE_COUNT_RESET = PROBE_COUNT_W'(6);
    localparam logic [LINE_COUNT_W-1:0]  LINE_COUNT_RESET  = '0;

    // register index, taken from paddr[2]
    localparam logic REG_PROBE_COUNT = 1'b0;
    localparam logic REG_LINE_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // double-hashing step: key hash rotated right
    function automatic logic [HASH_W-1:0] rot_delta(input logic [HASH_W-1:0] x);
        rot_delta = {x[ROT_DELTA-1:0], x[HASH_W-1:ROT_DELTA]};
    endfunction

endpackage

// ===== hdl/clbf_ram.sv =====
// generic single-port ram with registered read
// no dependencies; holds the filter line store
module clbf_ram #(
    parameter int WIDTH = 512,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cache_line_bloom_filter.sv =====
// top level of the cache-line blocked bloom filter: sequencer, serial divider,
// probe datapath and configuration port; uses clbf_pkg and clbf_ram
//
// Each request carries an operation in s_tuser and a 32-bit key hash in s_tdata.
// An insert sets probe_count bits inside one 512-bit line, a query answers on
// m_tdata[0] whether all those bits are set, a clear zeroes the whole store.
// The line is key_hash mod line_count, found by a restoring divider that
// retires one quotient bit per cycle. The line is then read once,
// the probes walk through it at one per cycle, and an insert writes it back.
// From accept until the block is ready again, an insert or a query passes
// through the divider, the read and load steps, the probe walk and the step
// that ends it, then one step that writes the line back or posts the
// answer; a query whose answer finds the output register still full waits
// there until it frees up. When LINE_BITS is not a power of two two more
// divider passes find the first probe position and the probe step inside
// the line. A clear, and reset, sweep the store one line per cycle, during
// which s_tready is low; configuration writes are still taken then.
// With line_count 0 the filter is empty: inserts are dropped at once and
// queries answer 0. A result waits in an output register, so the next request
// is accepted while the previous answer has not yet been taken.
// Registers: probe_count at byte address 0, line_count at byte address 4.
module cache_line_bloom_filter #(
    parameter int MAX_LINES = clbf_pkg::MAX_LINES_DEF,
    parameter int LINE_BITS = clbf_pkg::LINE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [clbf_pkg::HASH_W-1:0]      s_tdata,   // [31:0] key_hash
    input  logic [1:0]                       s_tuser,   // [1:0] op
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [clbf_pkg::M_TDATA_W-1:0]   m_tdata,   // [0] may_match, [7:1] zero
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [clbf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [clbf_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [clbf_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);

    import clbf_pkg::*;

    // line index width
    localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    // bit position inside a line
    localparam int PW = $clog2(LINE_BITS);
    // divider remainder width, covers both line count and line size
    localparam int LB_W = $clog2(LINE_BITS + 1);
    localparam int DW = (LINE_COUNT_W > LB_W) ? LINE_COUNT_W : LB_W;
    localparam int DIV_CNT_W = $clog2(HASH_W);
    localparam bit LINE_POW2 = ((LINE_BITS & (LINE_BITS - 1)) == 0);
    // 2^32 mod LINE_BITS, removed from the position when the hash sum wraps
    localparam longint unsigned WRAP_MOD = (64'd1 << HASH_W) % LINE_BITS;

    localparam logic [PW:0]          LB_EXT   = (PW + 1)'(LINE_BITS);
    localparam logic [PW:0]          WRAP_EXT = (PW + 1)'(WRAP_MOD);
    localparam logic [AW-1:0]        LAST_LINE = AW'(MAX_LINES - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(HASH_W - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_LOAD,
        ST_PROBE,
        ST_WRITE,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        PASS_LINE,
        PASS_POS,
        PASS_DELTA
    } pass_t;

    // control state
    state_t                   state_reg, state_next;
    pass_t                    pass_reg, pass_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [AW-1:0]            clr_cnt_reg, clr_cnt_next;
    logic [PROBE_COUNT_W-1:0] probe_cnt_reg, probe_cnt_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic                     match_reg, match_next;
    logic [PROBE_COUNT_W-1:0] probe_count_reg;
    logic [LINE_COUNT_W-1:0]  line_count_reg;

    // datapath
    op_t                      op_reg, op_next;
    logic [HASH_W-1:0]        h_reg, h_next;
    logic [HASH_W-1:0]        delta_reg, delta_next;
    logic [HASH_W-1:0]        quo_reg, quo_next;
    logic [DW-1:0]            rem_reg, rem_next;
    logic [DW-1:0]            den_reg, den_next;
    logic [AW-1:0]            line_idx_reg, line_idx_next;
    logic [PW-1:0]            pos_reg, pos_next;
    logic [PW-1:0]            dm_reg, dm_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic                     all_set_reg, all_set_next;

    // shared divider step
    logic [DW:0]              trial;
    logic                     trial_ge;
    logic [DW-1:0]            rem_step;

    // probe step
    logic [PW:0]              sum1, s1, s2;
    logic [HASH_W:0]          hsum;
    logic [PW-1:0]            pos_step;
    logic [LINE_BITS-1:0]     line_set;

    logic [HASH_W-1:0]        lines_capped;
    logic [DW-1:0]            active_lines;
    logic                     s_accept;
    logic                     cfg_write;
    op_t                      op_in;

    logic                     ram_we;
    logic [AW-1:0]            ram_addr;
    logic [LINE_BITS-1:0]     ram_wdata;
    logic [LINE_BITS-1:0]     ram_rdata;

    clbf_ram #(
        .WIDTH(LINE_BITS),
        .DEPTH(MAX_LINES)
    ) u_store (
        .clk  (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == REG_LINE_COUNT) ? CFG_DATA_W'(line_count_reg)
                                                    : CFG_DATA_W'(probe_count_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign op_in    = op_t'(s_tuser);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(match_reg);

    // a line count beyond the store acts as the full store
    assign lines_capped = (HASH_W'(line_count_reg) > HASH_W'(MAX_LINES))
                          ? HASH_W'(MAX_LINES) : HASH_W'(line_count_reg);
    assign active_lines = DW'(lines_capped);

    // restoring division, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[HASH_W-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});
    assign rem_step = trial_ge ? DW'(trial - {1'b0, den_reg}) : DW'(trial);

    // next probe position, kept reduced mod LINE_BITS while the 32-bit hash
    // sum advances alongside to see where it wraps
    assign sum1 = {1'b0, pos_reg} + {1'b0, dm_reg};
    assign s1   = (sum1 >= LB_EXT) ? (sum1 - LB_EXT) : sum1;
    assign hsum = {1'b0, h_reg} + {1'b0, delta_reg};
    always_comb begin
        if (hsum[HASH_W]) begin
            s2 = (s1 >= WRAP_EXT) ? (s1 - WRAP_EXT) : (s1 + LB_EXT - WRAP_EXT);
        end else begin
            s2 = s1;
        end
    end
    assign pos_step = PW'(s2);
    assign line_set = line_reg | (LINE_BITS'(1) << pos_reg);

    // store port: clearing sweep, or the line of the current request
    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign ram_addr  = (state_reg == ST_CLEAR) ? clr_cnt_reg : line_idx_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : line_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        div_cnt_next   = div_cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        probe_cnt_next = probe_cnt_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_tready;
        match_next     = match_reg;
        op_next        = op_reg;
        h_next         = h_reg;
        delta_next     = delta_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        line_idx_next  = line_idx_reg;
        pos_next       = pos_reg;
        dm_next        = dm_reg;
        line_next      = line_reg;
        all_set_next   = all_set_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_LINE) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    op_next    = op_in;
                    h_next     = s_tdata;
                    delta_next = rot_delta(s_tdata);
                    case (op_in)
                        OP_CLEAR: begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        OP_INSERT, OP_QUERY: begin
                            if (active_lines == '0) begin
                                // empty filter: queries miss, inserts dropped
                                all_set_next = 1'b0;
                                if (op_in == OP_QUERY) begin
                                    state_next = ST_RESP;
                                end
                            end else begin
                                quo_next     = s_tdata;
                                rem_next     = '0;
                                den_next     = active_lines;
                                div_cnt_next = '0;
                                pass_next    = PASS_LINE;
                                state_next   = ST_DIV;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                rem_next     = rem_step;
                quo_next     = {quo_reg[HASH_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST) begin
                    case (pass_reg)
                        PASS_LINE: begin
                            line_idx_next = AW'(rem_step);
                            if (LINE_POW2) begin
                                pos_next   = h_reg[PW-1:0];
                                dm_next    = delta_reg[PW-1:0];
                                state_next = ST_READ;
                            end else begin
                                quo_next  = h_reg;
                                rem_next  = '0;
                                den_next  = DW'(LINE_BITS);
                                pass_next = PASS_POS;
                            end
                        end
                        PASS_POS: begin
                            pos_next  = PW'(rem_step);
                            quo_next  = delta_reg;
                            rem_next  = '0;
                            pass_next = PASS_DELTA;
                        end
                        PASS_DELTA: begin
                            dm_next    = PW'(rem_step);
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_READ;
                        end
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                line_next      = ram_rdata;
                probe_cnt_next = '0;
                all_set_next   = 1'b1;
                state_next     = ST_PROBE;
            end
            ST_PROBE: begin
                if (probe_cnt_reg == probe_count_reg) begin
                    state_next = (op_reg == OP_INSERT) ? ST_WRITE : ST_RESP;
                end else begin
                    if (op_reg == OP_INSERT) begin
                        line_next = line_set;
                    end else if (!line_reg[pos_reg]) begin
                        all_set_next = 1'b0;
                    end
                    pos_next       = pos_step;
                    h_next         = hsum[HASH_W-1:0];
                    probe_cnt_next = probe_cnt_reg + PROBE_COUNT_W'(1);
                end
            end
            ST_WRITE: begin
                state_next = ST_IDLE;
            end
            ST_RESP: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    match_next    = all_set_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, result register and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            pass_reg        <= PASS_LINE;
            div_cnt_reg     <= '0;
            clr_cnt_reg     <= '0;
            probe_cnt_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
            match_reg       <= 1'b0;
            probe_count_reg <= PROBE_COUNT_RESET;
            line_count_reg  <= LINE_COUNT_RESET;
        end else begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            div_cnt_reg   <= div_cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            probe_cnt_reg <= probe_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
            match_reg     <= match_next;
            if (cfg_write) begin
                case (paddr[2])
                    REG_PROBE_COUNT: probe_count_reg <= pwdata[PROBE_COUNT_W-1:0];
                    REG_LINE_COUNT:  line_count_reg  <= pwdata[LINE_COUNT_W-1:0];
                    default:         line_count_reg  <= line_count_reg;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        h_reg        <= h_next;
        delta_reg    <= delta_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        line_idx_reg <= line_idx_next;
        pos_reg      <= pos_next;
        dm_reg       <= dm_next;
        line_reg     <= line_next;
        all_set_reg  <= all_set_next;
    end

    // the store is never written while a request can be taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !s_tready)
        else $error("store written while accepting requests");

    // divider remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder out of range");

    // a result only appears from the response step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result raised outside response step");

    // the line read always lies inside the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (32'(line_idx_reg) < 32'(MAX_LINES)))
        else $error("line index beyond store");

endmodule
